>>> sv/cddu_pkg.sv
package cddu_pkg;

	localparam int unsigned LAST_YEAR = 16383;

	localparam int YEAR_W = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W = 5;
	localparam int DOY_W = 9;
	localparam int DNUM_W = 23;
	localparam int RESULT_W = 24;

	// floor(x / 100) = (x * RECIP_100) >> 19 and floor(x / 400) = (x * RECIP_100) >> 21,
	// exact for x below 43690
	localparam logic [12:0] RECIP_100 = 13'd5243;
	localparam int SHIFT_100 = 19;
	localparam int SHIFT_400 = 21;

	typedef enum logic [1:0] {
		MODE_DIFF    = 2'd0,
		MODE_WEEKDAY = 2'd1,
		MODE_DOY     = 2'd2
	} mode_t;

	// stage advance enables handed to the date units
	typedef struct packed {
		logic s2;
		logic s3;
	} adv_t;

	function automatic logic [DOY_W-1:0] days_before_month(input logic [3:0] mi);
		logic [DOY_W-1:0] d;
		case (mi)
			4'd0:    d = 9'd0;
			4'd1:    d = 9'd31;
			4'd2:    d = 9'd59;
			4'd3:    d = 9'd90;
			4'd4:    d = 9'd120;
			4'd5:    d = 9'd151;
			4'd6:    d = 9'd181;
			4'd7:    d = 9'd212;
			4'd8:    d = 9'd243;
			4'd9:    d = 9'd273;
			4'd10:   d = 9'd304;
			default: d = 9'd334;
		endcase
		return d;
	endfunction

endpackage

>>> sv/cddu_day_number.sv
module cddu_day_number (
	input  logic                                clk,
	input  cddu_pkg::adv_t                      adv,
	input  logic [cddu_pkg::YEAR_W-1:0]         year,
	input  logic [cddu_pkg::MONTH_W-1:0]        month,
	input  logic [cddu_pkg::DAY_W-1:0]          day,
	output logic [cddu_pkg::DNUM_W-1:0]         day_number,
	output logic [cddu_pkg::DOY_W-1:0]          day_of_year
);

	logic [cddu_pkg::YEAR_W-1:0] y;
	logic [3:0]                  mi;
	logic [cddu_pkg::DOY_W-1:0]  doy_base;
	logic [14:0]                 y_p3;
	logic [14:0]                 y_p99;
	logic [14:0]                 y_p399;
	logic [27:0]                 prod_c100;
	logic [27:0]                 prod_f100;
	logic [27:0]                 prod_c400;
	logic [27:0]                 prod_f400;

	logic [cddu_pkg::YEAR_W-1:0] y_s2;
	logic [cddu_pkg::DOY_W-1:0]  doy_base_s2;
	logic                        late_s2;
	logic [12:0]                 c4_s2;
	logic [7:0]                  c100_s2;
	logic [7:0]                  f100_s2;
	logic [5:0]                  c400_s2;
	logic [5:0]                  f400_s2;

	logic                        leap;
	logic [12:0]                 leaps;
	logic [cddu_pkg::DOY_W-1:0]  doy;
	logic [cddu_pkg::DNUM_W-1:0] dnum;

	always_comb begin
		if (32'(year) > cddu_pkg::LAST_YEAR) begin
			y = cddu_pkg::YEAR_W'(cddu_pkg::LAST_YEAR);
		end else begin
			y = year;
		end
		if (month == 4'd0) begin
			mi = 4'd0;
		end else if (month > 4'd12) begin
			mi = 4'd11;
		end else begin
			mi = month - 4'd1;
		end
		doy_base = cddu_pkg::days_before_month(mi) + cddu_pkg::DOY_W'(day);
		y_p3   = 15'(y) + 15'd3;
		y_p99  = 15'(y) + 15'd99;
		y_p399 = 15'(y) + 15'd399;
		prod_c100 = 28'(y_p99) * 28'(cddu_pkg::RECIP_100);
		prod_f100 = 28'(y) * 28'(cddu_pkg::RECIP_100);
		prod_c400 = 28'(y_p399) * 28'(cddu_pkg::RECIP_100);
		prod_f400 = 28'(y) * 28'(cddu_pkg::RECIP_100);
	end

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			y_s2        <= y;
			doy_base_s2 <= doy_base;
			late_s2     <= (mi >= 4'd2);
			c4_s2       <= y_p3[14:2];
			c100_s2     <= prod_c100[cddu_pkg::SHIFT_100 +: 8];
			f100_s2     <= prod_f100[cddu_pkg::SHIFT_100 +: 8];
			c400_s2     <= prod_c400[cddu_pkg::SHIFT_400 +: 6];
			f400_s2     <= prod_f400[cddu_pkg::SHIFT_400 +: 6];
		end
	end

	// a year is a multiple of 100 (400) exactly when its ceiling and floor quotients agree
	always_comb begin
		leap  = (y_s2[1:0] == 2'd0) && ((c100_s2 != f100_s2) || (c400_s2 == f400_s2));
		leaps = c4_s2 - 13'(c100_s2) + 13'(c400_s2);
		doy   = doy_base_s2 + cddu_pkg::DOY_W'(late_s2 && leap);
		dnum  = cddu_pkg::DNUM_W'(y_s2) * cddu_pkg::DNUM_W'(365)
		      + cddu_pkg::DNUM_W'(leaps) + cddu_pkg::DNUM_W'(doy);
	end

	always_ff @(posedge clk) begin
		if (adv.s3) begin
			day_number  <= dnum;
			day_of_year <= doy;
		end
	end

endmodule

>>> sv/calendar_day_difference_unit.sv
// Proleptic Gregorian date unit. Each transaction carries a mode in tuser and two
// dates A and B in tdata; the result transaction carries the signed day count A - B
// (mode 0), the weekday of A with Monday = 1 .. Sunday = 7 (mode 1), or the day of
// year of A (mode 2); mode 3 returns 0. Months outside 1..12 clamp to January or
// December, and a day past the month end is counted on linearly. The unit takes one
// transaction per clock unless the output is stalled; the result passes through four
// register levels: input, divider quotients, day numbers and result. Back-pressure on
// the output holds a stage only while every stage after it is occupied, so empty
// stages still close up behind a stalled result.
module calendar_day_difference_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// year_a[13:0], month_a[17:14], day_a[22:18], year_b[36:23], month_b[40:37],
	// day_b[45:41], zero fill [47:46]
	input  logic [47:0] s_axis_tdata,
	// mode[1:0]
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// result[23:0], signed
	output logic [23:0] m_axis_tdata
);

	logic                              v1_q, v2_q, v3_q, out_valid_q;
	logic                              mv_out, mv3, mv2, mv1;
	cddu_pkg::adv_t                    adv;

	cddu_pkg::mode_t                   mode_s1, mode_s2, mode_s3;
	logic [cddu_pkg::YEAR_W-1:0]       year_a_s1, year_b_s1;
	logic [cddu_pkg::MONTH_W-1:0]      month_a_s1, month_b_s1;
	logic [cddu_pkg::DAY_W-1:0]        day_a_s1, day_b_s1;

	logic [cddu_pkg::DNUM_W-1:0]       na, nb;
	logic [cddu_pkg::DOY_W-1:0]        doy_a, doy_b;

	logic signed [cddu_pkg::RESULT_W-1:0] diff;
	logic [cddu_pkg::RESULT_W-1:0]     wk_arg;
	logic [2:0]                        weekday;
	logic [cddu_pkg::RESULT_W-1:0]     result;
	logic [cddu_pkg::RESULT_W-1:0]     result_q;

	// 8 = 1 (mod 7): fold octal digits
	function automatic logic [2:0] mod7(input logic [23:0] x);
		logic [5:0] s;
		logic [3:0] t;
		logic [2:0] r;
		s = '0;
		for (int i = 0; i < 8; i++) begin
			s = s + 6'(x[3*i +: 3]);
		end
		t = 4'(s[5:3]) + 4'(s[2:0]);
		if (t >= 4'd14) begin
			r = 3'(t - 4'd14);
		end else if (t >= 4'd7) begin
			r = 3'(t - 4'd7);
		end else begin
			r = t[2:0];
		end
		return r;
	endfunction

	assign mv_out = !out_valid_q || m_axis_tready;
	assign mv3    = !v3_q || mv_out;
	assign mv2    = !v2_q || mv3;
	assign mv1    = !v1_q || mv2;
	assign adv.s2 = mv2;
	assign adv.s3 = mv3;

	assign s_axis_tready = mv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q        <= 1'b0;
			v2_q        <= 1'b0;
			v3_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (mv1) v1_q <= s_axis_tvalid;
			if (mv2) v2_q <= v1_q;
			if (mv3) v3_q <= v2_q;
			if (mv_out) out_valid_q <= v3_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mv1) begin
			mode_s1    <= cddu_pkg::mode_t'(s_axis_tuser);
			year_a_s1  <= s_axis_tdata[13:0];
			month_a_s1 <= s_axis_tdata[17:14];
			day_a_s1   <= s_axis_tdata[22:18];
			year_b_s1  <= s_axis_tdata[36:23];
			month_b_s1 <= s_axis_tdata[40:37];
			day_b_s1   <= s_axis_tdata[45:41];
		end
		if (mv2) mode_s2 <= mode_s1;
		if (mv3) mode_s3 <= mode_s2;
		if (mv_out) result_q <= result;
	end

	cddu_day_number u_date_a (
		.clk         (clk),
		.adv         (adv),
		.year        (year_a_s1),
		.month       (month_a_s1),
		.day         (day_a_s1),
		.day_number  (na),
		.day_of_year (doy_a)
	);

	cddu_day_number u_date_b (
		.clk         (clk),
		.adv         (adv),
		.year        (year_b_s1),
		.month       (month_b_s1),
		.day         (day_b_s1),
		.day_number  (nb),
		.day_of_year (doy_b)
	);

	always_comb begin
		diff    = $signed({1'b0, na}) - $signed({1'b0, nb});
		// day number 1 (0-01-01) is a Saturday, weekday 6
		wk_arg  = cddu_pkg::RESULT_W'(na) + cddu_pkg::RESULT_W'(4);
		weekday = mod7(wk_arg) + 3'd1;
		case (mode_s3)
			cddu_pkg::MODE_DIFF:    result = diff;
			cddu_pkg::MODE_WEEKDAY: result = cddu_pkg::RESULT_W'(weekday);
			cddu_pkg::MODE_DOY:     result = cddu_pkg::RESULT_W'(doy_a);
			default:                result = '0;
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = result_q;

	a_full_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (v1_q && v2_q && v3_q && out_valid_q))
		else $error("input stalled while a pipeline stage is empty");

	a_weekday_range: assert property (@(posedge clk) disable iff (!arst_n)
		(v3_q && mode_s3 == cddu_pkg::MODE_WEEKDAY) |-> (weekday != 3'd0))
		else $error("weekday out of range");

	a_doy_range: assert property (@(posedge clk) disable iff (!arst_n)
		v3_q |-> (doy_a <= 9'd366 && doy_b <= 9'd366))
		else $error("day of year out of range");

	a_result_load: assert property (@(posedge clk) disable iff (!arst_n)
		(v3_q && mv_out) |=> (out_valid_q && m_axis_tdata == $past(result)))
		else $error("result register missed a completed item");

endmodule

>>> bench/tb_calendar_day_difference_unit.sv
module tb_calendar_day_difference_unit;
	import cddu_pkg::*;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 12;
	localparam int HOLD_CYCLES = 300;

	// cumulative days before each month in a common year
	localparam int MONTH_START [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

	typedef struct {
		logic [1:0]  mode;
		logic [47:0] data;
	} date_req_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;

	date_req_t   pending_dates[$];
	logic [23:0] expected_results[$];
	date_req_t   next_req;
	logic [23:0] want_result;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	bit          pressure_on = 1'b0;
	bit          pressure_done = 1'b0;
	int          hold_left = 0;
	int          error_count = 0;
	int          cycle_count = 0;

	calendar_day_difference_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_tready),
		.s_axis_tdata  (s_tdata),
		.s_axis_tuser  (s_tuser),
		.m_axis_tvalid (m_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_tdata)
	);

	always #6 clk = ~clk;

	function automatic bit is_leap_year(int y);
		return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
	endfunction

	function automatic int year_day(int y, logic [3:0] m, logic [4:0] d);
		int mi;
		int doy;
		if (m == 4'd0)
			mi = 0;
		else if (m > 4'd12)
			mi = 11;
		else
			mi = int'(m) - 1;
		doy = MONTH_START[mi] + int'(d);
		if (mi >= 2 && is_leap_year(y))
			doy++;
		return doy;
	endfunction

	// 0-01-01 is day 1
	function automatic int serial_day(logic [13:0] yr, logic [3:0] m, logic [4:0] d);
		int y;
		int leaps;
		y = int'(yr);
		if (y > int'(LAST_YEAR))
			y = int'(LAST_YEAR);
		leaps = (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
		return y * 365 + leaps + year_day(y, m, d);
	endfunction

	function automatic logic [23:0] calc_date_result(logic [1:0] mode, logic [47:0] data);
		int day_a;
		int r;
		day_a = serial_day(data[13:0], data[17:14], data[22:18]);
		case (mode)
			MODE_DIFF:    r = day_a - serial_day(data[36:23], data[40:37], data[45:41]);
			MODE_WEEKDAY: r = ((day_a + 4) % 7) + 1;
			MODE_DOY:     r = year_day(int'(data[13:0]), data[17:14], data[22:18]);
			default:      r = 0;
		endcase
		return r[23:0];
	endfunction

	task automatic report_mismatch(string what, logic [23:0] want, logic [23:0] got);
		$display("mismatch at cycle %0d: %s, expected %0d got %0d", cycle_count, what,
			$signed(want), $signed(got));
		error_count++;
	endtask

	task automatic queue_date(logic [1:0] mode, logic [13:0] ya, logic [3:0] ma,
		logic [4:0] da, logic [13:0] yb, logic [3:0] mb, logic [4:0] db);
		date_req_t req;
		req.mode = mode;
		req.data = {2'b00, db, mb, yb, da, ma, ya};
		pending_dates.push_back(req);
	endtask

	function automatic logic [13:0] pick_year();
		int sel;
		sel = $urandom_range(3);
		if (sel == 0)
			return 14'($urandom_range(16383));
		else if (sel == 1)
			return 14'($urandom_range(163) * 100);
		else
			return 14'($urandom_range(2500, 1500));
	endfunction

	function automatic logic [3:0] pick_month();
		if ($urandom_range(9) < 8)
			return 4'($urandom_range(12, 1));
		return 4'($urandom_range(15));
	endfunction

	function automatic logic [4:0] pick_day();
		if ($urandom_range(9) < 7)
			return 5'($urandom_range(28, 1));
		return 5'($urandom_range(31));
	endfunction

	task automatic queue_random_dates(int count);
		int sel;
		logic [1:0]  mode;
		logic [13:0] ya;
		logic [13:0] yb;
		repeat (count) begin
			sel = $urandom_range(99);
			if (sel < 40)
				mode = MODE_DIFF;
			else if (sel < 65)
				mode = MODE_WEEKDAY;
			else if (sel < 90)
				mode = MODE_DOY;
			else
				mode = MODE_UNUSED;
			ya = pick_year();
			// keep some pairs close together so small differences show up
			if ($urandom_range(3) == 0)
				yb = 14'(ya + $urandom_range(2));
			else
				yb = pick_year();
			queue_date(mode, ya, pick_month(), pick_day(), yb, pick_month(), pick_day());
		end
	endtask

	task automatic drain_dates();
		while (pending_dates.size() != 0 || s_tvalid || expected_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
		end else begin
			if (s_tvalid && s_tready)
				expected_results.push_back(calc_date_result(s_tuser, s_tdata));
			if (!s_tvalid || s_tready) begin
				if (pending_dates.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_req = pending_dates.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= next_req.data;
					s_tuser <= next_req.mode;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: random stalls, plus one long hold-off when pressure is requested
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_left <= 0;
			pressure_done <= 1'b0;
		end else if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (pressure_on && !pressure_done) begin
			m_tready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			pressure_done <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result with nothing pending", '0, m_tdata);
			end else begin
				want_result = expected_results.pop_front();
				if (m_tdata !== want_result)
					report_mismatch("result", want_result, m_tdata);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// extremes, leap rules, clamped months and days out of range
		queue_date(MODE_DIFF, 14'd16383, 4'd12, 5'd31, 14'd0, 4'd1, 5'd1);
		queue_date(MODE_DIFF, 14'd0, 4'd1, 5'd0, 14'd16383, 4'd15, 5'd31);
		queue_date(MODE_DIFF, 14'd2024, 4'd3, 5'd1, 14'd2024, 4'd2, 5'd28);
		queue_date(MODE_DIFF, 14'd1900, 4'd3, 5'd1, 14'd1900, 4'd2, 5'd28);
		queue_date(MODE_DIFF, 14'd2000, 4'd3, 5'd1, 14'd2000, 4'd2, 5'd28);
		queue_date(MODE_DIFF, 14'd100, 4'd0, 5'd31, 14'd100, 4'd1, 5'd31);
		queue_date(MODE_DIFF, 14'd400, 4'd13, 5'd0, 14'd399, 4'd12, 5'd31);
		queue_date(MODE_DIFF, 14'd5, 4'd2, 5'd31, 14'd5, 4'd3, 5'd3);
		queue_date(MODE_DIFF, 14'd1234, 4'd6, 5'd15, 14'd1234, 4'd6, 5'd15);
		queue_date(MODE_WEEKDAY, 14'd0, 4'd1, 5'd1, 14'd0, 4'd0, 5'd0);
		queue_date(MODE_WEEKDAY, 14'd0, 4'd1, 5'd0, 14'd0, 4'd0, 5'd0);
		queue_date(MODE_WEEKDAY, 14'd2000, 4'd1, 5'd1, 14'd16383, 4'd15, 5'd31);
		queue_date(MODE_WEEKDAY, 14'd16383, 4'd12, 5'd31, 14'd0, 4'd0, 5'd0);
		queue_date(MODE_WEEKDAY, 14'd2024, 4'd15, 5'd31, 14'd0, 4'd0, 5'd0);
		queue_date(MODE_DOY, 14'd2000, 4'd12, 5'd31, 14'd0, 4'd0, 5'd0);
		queue_date(MODE_DOY, 14'd1900, 4'd12, 5'd31, 14'd0, 4'd0, 5'd0);
		queue_date(MODE_DOY, 14'd0, 4'd3, 5'd0, 14'd0, 4'd0, 5'd0);
		queue_date(MODE_DOY, 14'd16383, 4'd0, 5'd0, 14'd16383, 4'd15, 5'd31);
		queue_date(MODE_DOY, 14'd2024, 4'd14, 5'd31, 14'd0, 4'd0, 5'd0);
		queue_date(MODE_DOY, 14'd400, 4'd2, 5'd29, 14'd0, 4'd0, 5'd0);
		queue_date(MODE_UNUSED, 14'd16383, 4'd15, 5'd31, 14'd16383, 4'd15, 5'd31);
		queue_date(MODE_UNUSED, 14'd2024, 4'd5, 5'd5, 14'd1999, 4'd9, 5'd9);
		drain_dates();

		queue_random_dates(95);
		drain_dates();

		send_idle_pct = 52;
		queue_random_dates(95);
		drain_dates();

		send_idle_pct = 0;
		recv_idle_pct = 52;
		queue_random_dates(95);
		drain_dates();

		send_idle_pct = 26;
		recv_idle_pct = 26;
		queue_random_dates(95);
		drain_dates();

		// fill the pipeline behind a long output stall
		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_random_dates(50);
		pressure_on = 1'b1;
		drain_dates();

		if (expected_results.size() != 0)
			report_mismatch("results never delivered", expected_results[0], '0);
		if (error_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
